// ===== src/ordered_set_range_sum_unit_macros.svh =====
// Assertion macros for the range-sum unit.
`ifndef ORDERED_SET_RANGE_SUM_UNIT_MACROS_SVH
`define ORDERED_SET_RANGE_SUM_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define OSRS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define OSRS_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define OSRS_ASSERT(label, clk, rst_n, prop, msg)
`define OSRS_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

// ===== src/osrs_pkg.sv =====
`timescale 1ns / 1ps
package osrs_pkg;
	localparam int unsigned Capacity = 1024;
	localparam int unsigned AddrW = $clog2(Capacity);
	localparam int unsigned CountW = $clog2(Capacity + 1);
	localparam int unsigned KeyW = 30;
	localparam int unsigned SumW = 40;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_DUP = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_QUERY = 1'b1;
	localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

	typedef struct packed {
		logic             rd_en;
		logic [AddrW-1:0] rd_addr;
		logic             wr_en;
		logic [AddrW-1:0] wr_addr;
		logic [KeyW-1:0]  wr_data;
	} mem_req_t;
endpackage

// ===== src/ordered_set_range_sum_unit.sv =====
`timescale 1ns / 1ps
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | mode, key, range_low, range_high
// out     | out_valid | out_stall | sum, status
// One item at a time: it walks the key memory one entry a cycle, limited
// by the single read port. Reset empties the set at once via the entry
// count; no sweep.
// A stalled result holds in the output register; the next item is still
// taken and waits in DONE until the register frees.
module ordered_set_range_sum_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       mode,
	input  logic [osrs_pkg::KeyW-1:0]  key,
	input  logic [osrs_pkg::KeyW-1:0]  range_low,
	input  logic [osrs_pkg::KeyW-1:0]  range_high,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [osrs_pkg::SumW-1:0]  sum,
	output logic [1:0]                 status
);
	osrs_pkg::mem_req_t        mem_req;
	logic [osrs_pkg::KeyW-1:0] mem_rd_data;

	osrs_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.mode(mode), .key(key), .range_low(range_low), .range_high(range_high),
		.out_valid(out_valid), .out_stall(out_stall), .sum(sum), .status(status),
		.mem_req(mem_req), .mem_rd_data(mem_rd_data)
	);

	osrs_key_ram u_ram (
		.clk(clk), .req(mem_req), .rd_data(mem_rd_data)
	);
endmodule

// ===== src/osrs_key_ram.sv =====
`timescale 1ns / 1ps
module osrs_key_ram (
	input  logic                  clk,
	input  osrs_pkg::mem_req_t    req,
	output logic [osrs_pkg::KeyW-1:0] rd_data
);
	logic [osrs_pkg::KeyW-1:0] mem [osrs_pkg::Capacity];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end
endmodule

// ===== src/osrs_ctrl.sv =====
`timescale 1ns / 1ps
`include "ordered_set_range_sum_unit_macros.svh"
module osrs_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic                       mode,
	input  logic [osrs_pkg::KeyW-1:0]  key,
	input  logic [osrs_pkg::KeyW-1:0]  range_low,
	input  logic [osrs_pkg::KeyW-1:0]  range_high,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [osrs_pkg::SumW-1:0]  sum,
	output logic [1:0]                 status,
	output osrs_pkg::mem_req_t         mem_req,
	input  logic [osrs_pkg::KeyW-1:0]  mem_rd_data
);
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_SCAN = 2'd1;
	localparam logic [1:0] S_DONE = 2'd2;

	logic [1:0]                  state_q;
	logic [osrs_pkg::CountW-1:0] count_q;
	logic [osrs_pkg::CountW-1:0] idx_q;
	logic                        rd_pend_q;
	logic                        mode_q;
	logic [osrs_pkg::KeyW-1:0]   key_q, lo_q, hi_q;
	logic [osrs_pkg::SumW-1:0]   acc_q;
	logic                        found_q;
	logic                        out_valid_q;
	logic [osrs_pkg::SumW-1:0]   sum_q;
	logic [1:0]                  status_q;

	logic accept, emit, out_free, inverted;
	logic [osrs_pkg::SumW:0] acc_add;
	logic hit;

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign accept = in_valid && (state_q == S_IDLE);
	assign emit = (state_q == S_DONE) && out_free;
	assign inverted = lo_q > hi_q;
	assign hit = (mode_q == osrs_pkg::MODE_QUERY) ? (mem_rd_data >= lo_q && mem_rd_data <= hi_q)
		: (mem_rd_data == key_q);
	assign acc_add = {1'b0, acc_q} + {{(osrs_pkg::SumW + 1 - osrs_pkg::KeyW){1'b0}}, mem_rd_data};

	always_comb begin
		mem_req.rd_en = (state_q == S_SCAN) && (idx_q < count_q);
		mem_req.rd_addr = idx_q[osrs_pkg::AddrW-1:0];
		mem_req.wr_en = (state_q == S_DONE) && emit && (mode_q == osrs_pkg::MODE_INSERT)
			&& !found_q && (count_q < osrs_pkg::CountW'(osrs_pkg::Capacity));
		mem_req.wr_addr = count_q[osrs_pkg::AddrW-1:0];
		mem_req.wr_data = key_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			rd_pend_q <= 1'b0;
			out_valid_q <= 1'b0;
			found_q <= 1'b0;
			acc_q <= '0;
		end else begin
			if (out_valid_q && !out_stall && !emit) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_SCAN;
						idx_q <= '0;
						rd_pend_q <= 1'b0;
						acc_q <= '0;
						found_q <= 1'b0;
					end
				end
				S_SCAN: begin
					// one entry read per cycle, result consumed the next
					rd_pend_q <= mem_req.rd_en;
					if (mem_req.rd_en) begin
						idx_q <= idx_q + 1'b1;
					end
					if (rd_pend_q && hit) begin
						found_q <= 1'b1;
						if (mode_q == osrs_pkg::MODE_QUERY) begin
							acc_q <= acc_add[osrs_pkg::SumW] ? osrs_pkg::SumMax
								: acc_add[osrs_pkg::SumW-1:0];
						end
					end
					if (!mem_req.rd_en && !rd_pend_q) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (emit) begin
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
						if (mem_req.wr_en) begin
							count_q <= count_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode;
			key_q <= key;
			lo_q <= range_low;
			hi_q <= range_high;
		end
		if (emit) begin
			if (mode_q == osrs_pkg::MODE_QUERY) begin
				sum_q <= inverted ? '0 : acc_q;
				status_q <= osrs_pkg::ST_OK;
			end else begin
				sum_q <= '0;
				if (found_q) begin
					status_q <= osrs_pkg::ST_DUP;
				end else if (count_q >= osrs_pkg::CountW'(osrs_pkg::Capacity)) begin
					status_q <= osrs_pkg::ST_FULL;
				end else begin
					status_q <= osrs_pkg::ST_OK;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign sum = sum_q;
	assign status = status_q;

	`OSRS_ASSERT_NEVER(a_count_range, clk, arst_n,
		count_q > osrs_pkg::CountW'(osrs_pkg::Capacity), "entry count beyond capacity")
	`OSRS_ASSERT(a_no_read_past_count, clk, arst_n,
		mem_req.rd_en |-> (idx_q < count_q), "read beyond stored entries")
	`OSRS_ASSERT(a_write_grows, clk, arst_n,
		mem_req.wr_en |=> (count_q == $past(count_q) + 1'b1), "write did not bump count")
	`OSRS_ASSERT_NEVER(a_emit_over_stall, clk, arst_n,
		emit && out_valid_q && out_stall, "result overwrote stalled beat")
endmodule
